[rtl/core/hbs_pkg.sv]
// Heightmap bilinear sampler package: sizes, payload words, register codes.
// Shared by every module under rtl/core; depends on nothing.
package hbs_pkg;

    localparam int MAX_GRID     = 64;
    localparam int STORE_DEPTH  = (MAX_GRID + 1) * (MAX_GRID + 1);
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int GRID_W       = $clog2(MAX_GRID + 1);
    localparam int HGT_W        = 16;
    localparam int POS_W        = 20;
    localparam int CW_W         = 9;
    localparam int FRAC_W       = 8;
    localparam int RES_W        = 24;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STAGES   = POS_W / DIV_BITS;
    // accept edge to the edge that samples done high
    localparam int PIPE_LATENCY = DIV_STAGES + 6;

    typedef enum logic
    {
        CFG_GRID_WIDTH = 1'b0,
        CFG_CELL_WIDTH = 1'b1
    } cfg_idx_t;

    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic                     req_type;
        logic [12:0]              entry_index;
        logic signed [HGT_W-1:0]  entry_height;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_z;
    } req_t;

    typedef struct packed
    {
        logic signed [RES_W-1:0]  height;
        logic                     out_of_range;
    } rsp_t;

    // write port and the four corner read addresses of the post store
    typedef struct packed
    {
        logic                     we;
        logic [12:0]              widx;
        logic signed [HGT_W-1:0]  wdata;
        logic [ADDR_W-1:0]        addr00;
        logic [ADDR_W-1:0]        addr01;
        logic [ADDR_W-1:0]        addr10;
        logic [ADDR_W-1:0]        addr11;
    } store_req_t;

    typedef struct packed
    {
        logic valid;
        logic query;
        logic oor;
    } blend_ctl_t;

endpackage

[rtl/core/hbs_divider.sv]
// Pipelined restoring divider: 20-bit dividend by 9-bit divisor, 4 bits a stage.
// Depends on hbs_pkg.
module hbs_divider
    import hbs_pkg::*;
(
    input  logic             clk,
    input  logic [POS_W-1:0] num,
    input  logic [CW_W-1:0]  den,
    output logic [POS_W-1:0] quo
);

    typedef struct packed
    {
        logic [CW_W-1:0]  rem;
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] quo;
    } div_st_t;

    function automatic div_st_t div_step(div_st_t s, logic [CW_W-1:0] d);
        div_st_t       o;
        logic [CW_W:0] t;
        o = s;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            t     = {o.rem, o.num[POS_W-1]};
            o.num = {o.num[POS_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t     = t - {1'b0, d};
                o.quo = {o.quo[POS_W-2:0], 1'b1};
            end
            else
            begin
                o.quo = {o.quo[POS_W-2:0], 1'b0};
            end
            o.rem = t[CW_W-1:0];
        end
        return o;
    endfunction

    div_st_t         st_reg  [DIV_STAGES];
    logic [CW_W-1:0] den_reg [DIV_STAGES];

    // advance one group of quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        div_st_t         st_in;
        logic [CW_W-1:0] den_in;
        if (k == 0)
        begin : g_first
            assign st_in  = '{rem: '0, num: num, quo: '0};
            assign den_in = den;
        end
        else
        begin : g_next
            assign st_in  = st_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            st_reg[k]  <= div_step(st_in, den_in);
            den_reg[k] <= den_in;
        end
    end

    assign quo = st_reg[DIV_STAGES-1].quo;

endmodule

[rtl/core/hbs_store.sv]
// Post store: four copies of the height grid, one per corner read, with a
// clearing pass after reset. Depends on hbs_pkg.
module hbs_store
    import hbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  store_req_t              sreq,
    output logic                    clearing,
    output logic signed [HGT_W-1:0] h00,
    output logic signed [HGT_W-1:0] h01,
    output logic signed [HGT_W-1:0] h10,
    output logic signed [HGT_W-1:0] h11
);

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HGT_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr [4];
    logic [HGT_W-1:0]  rdata [4];

    // sweep every entry to zero once after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // drop writes beyond the store
    assign we    = clr_busy_reg ||
                   (sreq.we && ({3'b0, sreq.widx} < 16'(STORE_DEPTH)));
    assign waddr = clr_busy_reg ? clr_cnt_reg : sreq.widx[ADDR_W-1:0];
    assign wdata = clr_busy_reg ? '0 : sreq.wdata;

    assign raddr[0] = sreq.addr00;
    assign raddr[1] = sreq.addr01;
    assign raddr[2] = sreq.addr10;
    assign raddr[3] = sreq.addr11;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [HGT_W-1:0] mem [STORE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            rdata[b] <= mem[raddr[b]];
        end
    end

    assign clearing = clr_busy_reg;
    assign h00      = $signed(rdata[0]);
    assign h01      = $signed(rdata[1]);
    assign h10      = $signed(rdata[2]);
    assign h11      = $signed(rdata[3]);

endmodule

[rtl/core/hbs_blend.sv]
// Bilinear blend pipeline: x lerp products, sums, z lerp products, final sum
// with truncation toward zero. Depends on hbs_pkg.
module hbs_blend
    import hbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  blend_ctl_t              ctl,
    input  logic signed [HGT_W-1:0] h00,
    input  logic signed [HGT_W-1:0] h01,
    input  logic signed [HGT_W-1:0] h10,
    input  logic signed [HGT_W-1:0] h11,
    input  logic [FRAC_W-1:0]       fx,
    input  logic [FRAC_W-1:0]       fz,
    output logic                    done,
    output rsp_t                    rsp
);

    blend_ctl_t         d_ctl_reg, e_ctl_reg, f_ctl_reg;
    logic [FRAC_W-1:0]  d_fz_reg, e_fz_reg;
    logic signed [25:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [25:0] pa_reg, pb_reg;
    logic signed [34:0] ma_reg, mb_reg;
    logic               done_reg;
    rsp_t               rsp_reg;

    logic signed [25:0] wx0, wx1;
    logic signed [34:0] wz0, wz1;
    logic signed [35:0] sum;
    logic signed [35:0] sum_adj;
    logic signed [35:0] q8;

    assign wx0 = $signed({17'b0, 9'(9'd256 - {1'b0, fx})});
    assign wx1 = $signed({18'b0, fx});
    assign wz0 = $signed({26'b0, 9'(9'd256 - {1'b0, e_fz_reg})});
    assign wz1 = $signed({27'b0, e_fz_reg});

    // round toward zero on the divide by 256
    assign sum     = 36'(ma_reg) + 36'(mb_reg);
    assign sum_adj = sum[35] ? (sum + 36'sd255) : sum;
    assign q8      = sum_adj >>> FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctl_reg <= '0;
            e_ctl_reg <= '0;
            f_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            d_ctl_reg <= ctl;
            e_ctl_reg <= d_ctl_reg;
            f_ctl_reg <= e_ctl_reg;
            done_reg  <= f_ctl_reg.valid;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        p00_reg  <= 26'(h00) * wx0;
        p01_reg  <= 26'(h01) * wx1;
        p10_reg  <= 26'(h10) * wx0;
        p11_reg  <= 26'(h11) * wx1;
        d_fz_reg <= fz;
        pa_reg   <= p00_reg + p01_reg;
        pb_reg   <= p10_reg + p11_reg;
        e_fz_reg <= d_fz_reg;
        ma_reg   <= 35'(pa_reg) * wz0;
        mb_reg   <= 35'(pb_reg) * wz1;
        rsp_reg.out_of_range <= f_ctl_reg.query && f_ctl_reg.oor;
        rsp_reg.height       <= (f_ctl_reg.query && !f_ctl_reg.oor) ? q8[RES_W-1:0] : '0;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[rtl/core/heightmap_bilinear_sampler.sv]
// Heightmap bilinear sampler top: config registers, divide, address, store, blend.
// Depends on hbs_pkg, hbs_divider, hbs_store and hbs_blend.
//
//   port group          dir  handshake               word
//   start/busy/req      in   start & !busy           req_t
//   done/rsp            out  done, one cycle         rsp_t
//   cfg_we/idx/data     in   cfg_we                  9-bit register value
//
// One word per cycle while busy is low; each result follows its word through five
// divider stages, address, store read and four blend stages.
// After reset busy stays high while every store entry is swept to zero.
// Results cannot be held off; the pipeline never stalls and words stay in order.
// A write is visible to the next word accepted after it.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  req_t            req,
    output logic            done,
    output rsp_t            rsp,
    input  logic            cfg_we,
    input  logic            cfg_idx,
    input  logic [CW_W-1:0] cfg_data
);

    logic [6:0]        grid_width_reg;
    logic [CW_W-1:0]   cell_width_reg;
    logic [CW_W-1:0]   cw_eff;
    logic [GRID_W-1:0] w_eff;
    logic              accept;
    logic              clearing;

    logic [POS_W-1:0]  qx, qz;

    logic [DIV_STAGES-1:0]   vld_reg;
    logic                    typ_reg [DIV_STAGES];
    logic [12:0]             idx_reg [DIV_STAGES];
    logic signed [HGT_W-1:0] hgt_reg [DIV_STAGES];

    logic                    a_vld_reg, a_query_reg, a_oor_reg;
    logic [FRAC_W-1:0]       a_fx_reg, a_fz_reg;
    logic [GRID_W-1:0]       a_col0_reg, a_col1_reg;
    logic [ADDR_W-1:0]       a_base0_reg, a_base1_reg;
    logic [12:0]             a_idx_reg;
    logic signed [HGT_W-1:0] a_hgt_reg;

    logic              b_vld_reg, b_query_reg, b_oor_reg;
    logic [FRAC_W-1:0] b_fx_reg, b_fz_reg;

    logic [11:0]       col0, row0;
    logic              oor;
    logic [GRID_W-1:0] col1, row1;
    logic [GRID_W-1:0] w_p1;

    store_req_t        sreq;
    blend_ctl_t        bctl;
    logic signed [HGT_W-1:0] h00, h01, h10, h11;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= 7'd64;
            cell_width_reg <= 9'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_GRID_WIDTH: grid_width_reg <= cfg_data[6:0];
                CFG_CELL_WIDTH: cell_width_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cw_eff = (cell_width_reg == '0) ? CW_W'(1) : cell_width_reg;
    assign w_eff  = (grid_width_reg == '0) ? GRID_W'(1) :
                    (grid_width_reg > 7'(MAX_GRID)) ? GRID_W'(MAX_GRID) :
                    grid_width_reg[GRID_W-1:0];
    assign w_p1   = w_eff + 1'b1;

    assign busy   = clearing;
    assign accept = start && !busy;

    hbs_divider u_div_x
    (
        .clk (clk),
        .num (req.pos_x),
        .den (cw_eff),
        .quo (qx)
    );

    hbs_divider u_div_z
    (
        .clk (clk),
        .num (req.pos_z),
        .den (cw_eff),
        .quo (qz)
    );

    // carry the word's kind and write payload beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        typ_reg[0] <= req.req_type;
        idx_reg[0] <= req.entry_index;
        hgt_reg[0] <= req.entry_height;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            typ_reg[k] <= typ_reg[k-1];
            idx_reg[k] <= idx_reg[k-1];
            hgt_reg[k] <= hgt_reg[k-1];
        end
    end

    // split the grid coordinate, check range, wrap the neighbours
    assign col0 = qx[POS_W-1:FRAC_W];
    assign row0 = qz[POS_W-1:FRAC_W];
    assign oor  = (col0 > 12'(w_eff)) || (row0 > 12'(w_eff));
    assign col1 = (col0[GRID_W-1:0] == w_eff) ? '0 : col0[GRID_W-1:0] + 1'b1;
    assign row1 = (row0[GRID_W-1:0] == w_eff) ? '0 : row0[GRID_W-1:0] + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= vld_reg[DIV_STAGES-1];
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_query_reg <= typ_reg[DIV_STAGES-1] == REQ_QUERY;
        a_oor_reg   <= oor;
        a_fx_reg    <= qx[FRAC_W-1:0];
        a_fz_reg    <= qz[FRAC_W-1:0];
        a_col0_reg  <= col0[GRID_W-1:0];
        a_col1_reg  <= col1;
        a_base0_reg <= ADDR_W'(row0[GRID_W-1:0] * w_p1);
        a_base1_reg <= ADDR_W'(row1 * w_p1);
        a_idx_reg   <= idx_reg[DIV_STAGES-1];
        a_hgt_reg   <= hgt_reg[DIV_STAGES-1];
        b_query_reg <= a_query_reg;
        b_oor_reg   <= a_oor_reg;
        b_fx_reg    <= a_fx_reg;
        b_fz_reg    <= a_fz_reg;
    end

    // issue corner reads and the write of a write word
    assign sreq.we     = a_vld_reg && !a_query_reg;
    assign sreq.widx   = a_idx_reg;
    assign sreq.wdata  = a_hgt_reg;
    assign sreq.addr00 = a_base0_reg + ADDR_W'(a_col0_reg);
    assign sreq.addr01 = a_base0_reg + ADDR_W'(a_col1_reg);
    assign sreq.addr10 = a_base1_reg + ADDR_W'(a_col0_reg);
    assign sreq.addr11 = a_base1_reg + ADDR_W'(a_col1_reg);

    hbs_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .sreq     (sreq),
        .clearing (clearing),
        .h00      (h00),
        .h01      (h01),
        .h10      (h10),
        .h11      (h11)
    );

    assign bctl = '{valid: b_vld_reg, query: b_query_reg, oor: b_oor_reg};

    hbs_blend u_blend
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bctl),
        .h00   (h00),
        .h01   (h01),
        .h10   (h10),
        .h11   (h11),
        .fx    (b_fx_reg),
        .fz    (b_fz_reg),
        .done  (done),
        .rsp   (rsp)
    );

    // every accepted word yields exactly one result, a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == ($past(start, PIPE_LATENCY) === 1'b1 &&
                 $past(busy, PIPE_LATENCY) === 1'b0))
        else $error("result strobe out of step with accepted words");

    // an out-of-range query reports a zero height
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.out_of_range |-> rsp.height == '0)
        else $error("out-of-range result with nonzero height");

    // the clearing pass runs once and does not restart
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy raised again after the clearing pass");

    // no strobe while the store is still being cleared
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result during clearing pass");

endmodule

[verif/tb_heightmap_bilinear_sampler.sv]
// Self-checking testbench for heightmap_bilinear_sampler: directed table, then random words.
// Depends on hbs_pkg and the heightmap_bilinear_sampler RTL.
module tb_heightmap_bilinear_sampler;
    import hbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        req_t  word;
        bit    fixed;
        rsp_t  known;
    } stim_row_t;

    typedef struct
    {
        bit    fixed;
        rsp_t  known;
    } hint_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    req_t            req;
    logic            done;
    rsp_t            rsp;
    logic            cfg_we;
    logic            cfg_idx;
    logic [CW_W-1:0] cfg_data;

    logic signed [HGT_W-1:0] posts [STORE_DEPTH];
    logic [6:0]              grid_reg;
    logic [8:0]              cell_reg;

    rsp_t  pending_heights [$];
    hint_t hint_q [$];
    int    errors;
    int    idle_pct;

    heightmap_bilinear_sampler dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Apply one word to the grid copy and return the height it yields
    function automatic rsp_t blend_height(input req_t w);
        rsp_t        r;
        int unsigned gw;
        int unsigned cw;
        int unsigned qx;
        int unsigned qz;
        int unsigned c0;
        int unsigned r0;
        int unsigned c1;
        int unsigned r1;
        longint      fx;
        longint      fz;
        longint      sum;
        r = '0;
        if (w.req_type == REQ_WRITE)
        begin
            if (w.entry_index < STORE_DEPTH)
                posts[w.entry_index] = w.entry_height;
            return r;
        end
        gw = (grid_reg == 0) ? 1 : ((grid_reg > MAX_GRID) ? MAX_GRID : grid_reg);
        cw = (cell_reg == 0) ? 1 : cell_reg;
        qx = w.pos_x / cw;
        qz = w.pos_z / cw;
        c0 = qx >> 8;
        r0 = qz >> 8;
        if (c0 > gw || r0 > gw)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        fx = qx & 8'hFF;
        fz = qz & 8'hFF;
        c1 = (c0 + 1 > gw) ? 0 : c0 + 1;
        r1 = (r0 + 1 > gw) ? 0 : r0 + 1;
        sum = longint'(posts[r0 * (gw + 1) + c0]) * (256 - fx) * (256 - fz)
            + longint'(posts[r0 * (gw + 1) + c1]) * fx * (256 - fz)
            + longint'(posts[r1 * (gw + 1) + c1]) * fx * fz
            + longint'(posts[r1 * (gw + 1) + c0]) * (256 - fx) * fz;
        r.height = RES_W'(sum / 256);
        return r;
    endfunction

    // Track config, predict on accept, check each result word
    always @(posedge clk)
    begin
        hint_t h;
        rsp_t  e;
        rsp_t  p;
        if (rst_n && cfg_we)
        begin
            if (cfg_idx == CFG_GRID_WIDTH)
                grid_reg = cfg_data[6:0];
            else
                cell_reg = cfg_data;
        end
        if (rst_n && done)
        begin
            if (pending_heights.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                e = pending_heights.pop_front();
                if (rsp.height !== e.height)
                    report_mismatch($sformatf("height %0d, want %0d", rsp.height, e.height));
                if (rsp.out_of_range !== e.out_of_range)
                    report_mismatch($sformatf("out_of_range %0b, want %0b",
                                              rsp.out_of_range, e.out_of_range));
            end
        end
        if (rst_n && start && !busy)
        begin
            h = hint_q.pop_front();
            p = blend_height(req);
            pending_heights.push_back(h.fixed ? h.known : p);
        end
    end

    // Drive one word at the falling edge and hold it until accepted
    task automatic send_word(input req_t w, input bit fixed, input rsp_t known);
        hint_t h;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        h.fixed = fixed;
        h.known = known;
        hint_q.push_back(h);
        start = 1'b1;
        req = w;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        while (pending_heights.size() != 0 || hint_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = CW_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic req_t make_write(input int idx, input int hgt);
        req_t w;
        w = '0;
        w.req_type = REQ_WRITE;
        w.entry_index = 13'(idx);
        w.entry_height = 16'(hgt);
        return w;
    endfunction

    function automatic req_t make_query(input int x, input int z);
        req_t w;
        w = '0;
        w.req_type = REQ_QUERY;
        w.pos_x = POS_W'(x);
        w.pos_z = POS_W'(z);
        return w;
    endfunction

    // Pick one coordinate, mostly landing in or just past the grid
    function automatic int pick_pos();
        int gw;
        int cw;
        longint v;
        gw = (grid_reg == 0) ? 1 : ((grid_reg > MAX_GRID) ? MAX_GRID : grid_reg);
        cw = (cell_reg == 0) ? 1 : cell_reg;
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(20'hFFFFF, 0);
        v = (longint'($urandom_range(gw + 1, 0)) * 256 + $urandom_range(255, 0)) * cw
            + $urandom_range(cw - 1, 0);
        return (v > 20'hFFFFF) ? 20'hFFFFF : int'(v);
    endfunction

    task automatic random_words(input int count);
        int gw;
        int span;
        rsp_t z;
        z = '0;
        gw = (grid_reg == 0) ? 1 : ((grid_reg > MAX_GRID) ? MAX_GRID : grid_reg);
        span = (gw + 1) * (gw + 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(2, 0) == 0)
            begin
                if ($urandom_range(9, 0) == 0)
                    send_word(make_write($urandom_range(8191, 0), $urandom()), 0, z);
                else
                    send_word(make_write($urandom_range(span - 1, 0), $urandom()), 0, z);
            end
            else
                send_word(make_query(pick_pos(), pick_pos()), 0, z);
        end
    endtask

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        int        cfgs [6][2];
        int        wait_cnt;
        errors = 0;
        idle_pct = 0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_GRID_WIDTH;
        cfg_data = '0;
        grid_reg = 7'd64;
        cell_reg = 9'd32;
        foreach (posts[i])
            posts[i] = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: fixed expectations where obvious, predictor elsewhere
        row.fixed = 1; row.known = '0;
        row.word = make_query(0, 0);                          table_rows.push_back(row);
        row.word = make_write(STORE_DEPTH - 1, 32767);        table_rows.push_back(row);
        row.word = make_write(8191, 1234);                    table_rows.push_back(row);
        row.word = make_write(STORE_DEPTH, -5);               table_rows.push_back(row);
        row.word = make_write(0, -32768);                     table_rows.push_back(row);
        row.word = make_query(0, 0);
        row.known.height = -24'sd8388608;                     table_rows.push_back(row);
        row.known = '0; row.known.out_of_range = 1'b1;
        row.word = make_query(20'hFFFFF, 0);                  table_rows.push_back(row);
        row.word = make_query(0, 20'hFFFFF);                  table_rows.push_back(row);
        row.word = make_query(20'hFFFFF, 20'hFFFFF);          table_rows.push_back(row);
        row.fixed = 0; row.known = '0;
        row.word = make_write(1, 32767);                      table_rows.push_back(row);
        row.word = make_write(65, -32768);                    table_rows.push_back(row);
        row.word = make_write(66, 32767);                     table_rows.push_back(row);
        row.word = make_write(64, 1000);                      table_rows.push_back(row);
        row.word = make_query(8191, 8191);                    table_rows.push_back(row);
        row.word = make_query(255 * 32, 128 * 32);            table_rows.push_back(row);
        row.word = make_query(64 * 256 * 32 + 8191, 8191);    table_rows.push_back(row);
        row.word = make_query(8191, 64 * 256 * 32 + 8191);    table_rows.push_back(row);
        row.word = make_query(64 * 256 * 32 + 31, 64 * 256 * 32 + 8191);
        table_rows.push_back(row);
        row.word = make_query(65 * 256 * 32, 0);              table_rows.push_back(row);
        foreach (table_rows[i])
            send_word(table_rows[i].word, table_rows[i].fixed, table_rows[i].known);

        // Walk register settings, extremes included, each under one of three idling mixes
        cfgs = '{'{64, 32}, '{0, 1}, '{127, 256}, '{1, 511}, '{5, 0}, '{40, 3}};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_GRID_WIDTH, cfgs[ph][0]);
            write_reg(CFG_CELL_WIDTH, cfgs[ph][1]);
            idle_pct = (ph % 3 == 0) ? 7 : ((ph % 3 == 1) ? 73 : 0);
            random_words(230);
        end

        wait_cnt = 0;
        while ((pending_heights.size() != 0 || hint_q.size() != 0) && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending_heights.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/hbs_pkg.sv
rtl/core/hbs_divider.sv
rtl/core/hbs_store.sv
rtl/core/hbs_blend.sv
rtl/core/heightmap_bilinear_sampler.sv
verif/tb_heightmap_bilinear_sampler.sv
